### design/hex_cell_geometry_defines.svh
// Assertion macros used by the hex cell geometry checker.
`ifndef HEX_CELL_GEOMETRY_DEFINES_SVH
`define HEX_CELL_GEOMETRY_DEFINES_SVH
// Same-cycle implication, off during reset.
`define HCG_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("hcg assertion failed");
// Next-cycle implication, off during reset.
`define HCG_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("hcg assertion failed");
// Condition that holds in the cycle after a reset cycle.
`define HCG_ASSERT_AFTER_RST(lbl, c) \
  lbl: assert property (@(posedge clk) $past(rst) |-> (c)) \
    else $error("hcg reset assertion failed");
`endif

### design/hcg_pkg.sv
// Shared constants and types for the hex cell geometry block.
package hcg_pkg;
  localparam logic [31:0] HALF_SQRT3_Q32 = 32'd3719550787;
  localparam logic [31:0] SHORT_OFF_Q32  = 32'd1239850264;
  localparam logic [31:0] LONG_OFF_Q32   = 32'd2479700524;
  localparam int          AXIAL_W   = 7;
  localparam int          QUERY_W   = 24;
  localparam int          CENTER_W  = 24;
  localparam int          RING_W    = 7;
  localparam int          DIST_W    = 23;
  localparam int          QDIST_W   = 32;
  localparam int          SCALE_W   = 24;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
  localparam logic [RING_W-1:0]  RING_MAX    = 7'd127;
  localparam longint CENTER_MAX = 64'sd8388607;
  localparam longint CENTER_MIN = -64'sd8388608;
  localparam int SIDE_W = 2 * CENTER_W + RING_W;

  typedef enum logic [1:0] {
    PICK_START,
    PICK_END,
    PICK_PROJ
  } edge_pick_t;
endpackage

### design/hcg_front.sv
// Front end: index clamp, ring number and cell centre.
module hcg_front import hcg_pkg::*; #(
  parameter int INDEX_LIMIT   = 63,
  parameter int FRACTION_BITS = 16,
  parameter int CW            = 26
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [AXIAL_W-1:0]  axial_u,
  input  logic signed [AXIAL_W-1:0]  axial_v,
  input  logic signed [QUERY_W-1:0]  query_x,
  input  logic signed [QUERY_W-1:0]  query_y,
  output logic                       q_valid,
  input  logic                       q_ready,
  output logic signed [CW-1:0]       cx,
  output logic signed [CW-1:0]       cy,
  output logic [RING_W-1:0]          ring,
  output logic signed [QUERY_W-1:0]  qx,
  output logic signed [QUERY_W-1:0]  qy
);
  localparam logic signed [7:0] LIM = 8'(INDEX_LIMIT > 64 ? 64 : INDEX_LIMIT);
  localparam int SH = 32 - FRACTION_BITS;

  logic signed [7:0] u_e, v_e, u_c, v_c;
  logic signed [8:0] s_w, d_w;
  logic [6:0]        au, av, amax;
  logic [7:0]        abs_s, ring8;
  logic              same;

  logic                      f1_valid;
  logic signed [8:0]         s1, d1;
  logic [RING_W-1:0]         ring1;
  logic signed [QUERY_W-1:0] qx1, qy1;

  logic              en1, en2;
  logic [7:0]        as2;
  logic [39:0]       prod, rnd;
  logic signed [CW-1:0] mag;

  assign en2      = !q_valid || q_ready;
  assign en1      = !f1_valid || en2;
  assign in_ready = en1;

  always_comb begin
    u_e   = 8'(axial_u);
    v_e   = 8'(axial_v);
    u_c   = (u_e > LIM) ? LIM : ((u_e < -LIM) ? -LIM : u_e);
    v_c   = (v_e > LIM) ? LIM : ((v_e < -LIM) ? -LIM : v_e);
    s_w   = 9'(u_c) + 9'(v_c);
    d_w   = 9'(u_c) - 9'(v_c);
    au    = u_c[7] ? 7'(-u_c) : 7'(u_c);
    av    = v_c[7] ? 7'(-v_c) : 7'(v_c);
    amax  = (au > av) ? au : av;
    abs_s = s_w[8] ? 8'(-s_w) : 8'(s_w);
    same  = ((u_c > 0) && (v_c > 0)) || ((u_c < 0) && (v_c < 0));
    ring8 = same ? abs_s : {1'b0, amax};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en1) begin
      f1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1    <= s_w;
      d1    <= d_w;
      ring1 <= (ring8 > 8'(RING_MAX)) ? RING_MAX : ring8[RING_W-1:0];
      qx1   <= query_x;
      qy1   <= query_y;
    end
  end

  always_comb begin
    as2  = s1[8] ? 8'(-s1) : 8'(s1);
    prod = 40'(as2) * 40'(HALF_SQRT3_Q32);
    rnd  = (prod + (40'd1 << (SH - 1))) >> SH;
    mag  = CW'(rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en2) begin
      q_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      cx   <= s1[8] ? -mag : mag;
      cy   <= CW'(d1) <<< (FRACTION_BITS - 1);
      ring <= ring1;
      qx   <= qx1;
      qy   <= qy1;
    end
  end
endmodule

### design/hcg_queue.sv
// Two-entry queue between the front end and the back end.
module hcg_queue #(
  parameter int W = 107
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         din_valid,
  output logic         din_ready,
  input  logic [W-1:0] din,
  output logic         dout_valid,
  input  logic         dout_ready,
  output logic [W-1:0] dout
);
  logic [W-1:0] mem [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;
  logic         push, pop;

  assign din_ready  = (count != 2'd2);
  assign dout_valid = (count != 2'd0);
  assign push       = din_valid && din_ready;
  assign pop        = dout_valid && dout_ready;
  assign dout       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

### design/hcg_isqrt.sv
// Pipelined integer square root, one root bit per stage, several lanes.
module hcg_isqrt #(
  parameter int NE    = 56,
  parameter int LANES = 3,
  parameter int TW    = 55
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [LANES-1:0][NE-1:0]       din,
  input  logic [TW-1:0]                  tag_in,
  output logic                           out_valid,
  output logic [LANES-1:0][NE/2-1:0]     root,
  output logic [TW-1:0]                  tag_out
);
  localparam int RW  = NE / 2;
  localparam int RMW = RW + 3;

  logic [RMW-1:0] rem_q  [LANES][RW];
  logic [RW-1:0]  root_q [LANES][RW];
  logic [NE-1:0]  n_q    [LANES][RW];
  logic [TW-1:0]  tag_q  [RW];
  logic           vld_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic          s_v;
    logic [TW-1:0] s_tag;
    if (k == 0) begin : g_first
      assign s_v   = in_valid;
      assign s_tag = tag_in;
    end else begin : g_next
      assign s_v   = vld_q[k-1];
      assign s_tag = tag_q[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= s_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_q[k] <= s_tag;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RMW-1:0] s_rem, cur, trial;
      logic [RW-1:0]  s_root;
      logic [NE-1:0]  s_n;
      logic           ge;
      if (k == 0) begin : g_first
        assign s_rem  = '0;
        assign s_root = '0;
        assign s_n    = din[l];
      end else begin : g_next
        assign s_rem  = rem_q[l][k-1];
        assign s_root = root_q[l][k-1];
        assign s_n    = n_q[l][k-1];
      end
      assign cur   = {s_rem[RMW-3:0], s_n[NE-1 -: 2]};
      assign trial = {1'b0, s_root, 2'b01};
      assign ge    = (cur >= trial);

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[l][k]  <= ge ? (cur - trial) : cur;
          root_q[l][k] <= {s_root[RW-2:0], ge};
          n_q[l][k]    <= s_n << 2;
        end
      end

      assign root[l] = root_q[l][RW-1];
    end
  end

  assign out_valid = vld_q[RW-1];
  assign tag_out   = tag_q[RW-1];
endmodule

### design/hcg_back.sv
// Back end: hexagon vertices, edge projection, distances and scaling.
module hcg_back import hcg_pkg::*; #(
  parameter int FRACTION_BITS = 16,
  parameter int CW            = 26,
  parameter int QW            = 27
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [CW-1:0]        cx,
  input  logic signed [CW-1:0]        cy,
  input  logic [RING_W-1:0]           ring,
  input  logic signed [QUERY_W-1:0]   qx,
  input  logic signed [QUERY_W-1:0]   qy,
  input  logic [SCALE_W-1:0]          scale,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [CENTER_W-1:0]  center_x,
  output logic signed [CENTER_W-1:0]  center_y,
  output logic [RING_W-1:0]           ring_number,
  output logic [DIST_W-1:0]           inner_distance,
  output logic [DIST_W-1:0]           outer_distance,
  output logic [QDIST_W-1:0]          query_distance
);
  localparam int F   = FRACTION_BITS;
  localparam int DW  = CW + F + 4;
  localparam int TW  = DW + 2;
  localparam int SW  = 2 * CW + 1;
  localparam int QSW = 2 * QW + 1;
  localparam int NE  = QSW + 1;
  localparam int RW  = NE / 2;
  localparam int OW  = 2 * F + 2;
  localparam int PW  = RW + SCALE_W;
  localparam longint SO = (longint'(SHORT_OFF_Q32) + (longint'(1) << (31 - F))) >>> (32 - F);
  localparam longint LO = (longint'(LONG_OFF_Q32) + (longint'(1) << (31 - F))) >>> (32 - F);
  localparam longint HF = longint'(1) << (F - 1);

  function automatic int nxt(input int i);
    return (i == 5) ? 0 : i + 1;
  endfunction

  function automatic longint off_x(input int i);
    longint r;
    case (i)
      0:       r = -SO;
      1:       r = SO;
      2:       r = LO;
      3:       r = SO;
      4:       r = -SO;
      default: r = -LO;
    endcase
    return r;
  endfunction

  function automatic longint off_y(input int i);
    longint r;
    case (i)
      0, 1:    r = -HF;
      3, 4:    r = HF;
      default: r = 0;
    endcase
    return r;
  endfunction

  function automatic longint edx(input int i);
    return off_x(nxt(i)) - off_x(i);
  endfunction

  function automatic longint edy(input int i);
    return off_y(nxt(i)) - off_y(i);
  endfunction

  function automatic longint labs(input longint a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic logic [2*CW-1:0] sq_c(input logic signed [CW-1:0] a);
    logic [CW-1:0] m;
    m = a[CW-1] ? CW'(-a) : CW'(a);
    return (2*CW)'(m) * (2*CW)'(m);
  endfunction

  function automatic logic [2*QW-1:0] sq_q(input logic signed [QW-1:0] a);
    logic [QW-1:0] m;
    m = a[QW-1] ? QW'(-a) : QW'(a);
    return (2*QW)'(m) * (2*QW)'(m);
  endfunction

  function automatic logic signed [CENTER_W-1:0] sat_c(input logic signed [CW-1:0] a);
    longint v;
    v = longint'(a);
    if (v > CENTER_MAX) begin
      v = CENTER_MAX;
    end else if (v < CENTER_MIN) begin
      v = CENTER_MIN;
    end
    return CENTER_W'(v);
  endfunction

  logic en;
  logic vb [6];
  logic [SIDE_W-1:0] sd [6];

  // stage 1: vertices and query offset
  logic signed [CW-1:0] p1x [6], p1y [6];
  logic signed [QW-1:0] qdx, qdy;
  // stage 2: dot products and squares
  logic signed [DW-1:0] dot [6];
  logic [SW-1:0]        vsq [6];
  logic [QSW-1:0]       q2, q3, q4, q5, q6;
  logic signed [CW-1:0] p2x [6], p2y [6], p3x [6], p3y [6];
  // stage 3: classify projection
  edge_pick_t           pick [6];
  logic [F:0]           tf [6];
  logic [SW-1:0]        vm3, vm4, vm5, vm6;
  // stage 4/5/6: closest point, its square, minimum
  logic signed [CW-1:0] ptx [6], pty [6];
  logic [SW-1:0]        esq [6];
  logic [SW-1:0]        emin;

  logic signed [TW-1:0] t_w [6], tt_w [6];
  edge_pick_t           pick_w [6];
  logic [SW-1:0]        vmax_w, emin_w;
  logic [OW-1:0]        ox_w [6], oy_w [6];
  logic signed [CW-1:0] offx_w [6], offy_w [6], ptx_w [6], pty_w [6];

  logic                         sq_valid;
  logic [2:0][NE-1:0]           sq_din;
  logic [2:0][RW-1:0]           sq_root;
  logic [SIDE_W-1:0]            sq_tag;

  logic                         m_valid;
  logic [SIDE_W-1:0]            m_side;
  logic [DIST_W-1:0]            m_inner, m_outer;
  logic [PW-1:0]                m_prod;
  logic [PW:0]                  qsum;
  logic [PW-F:0]                qs;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) begin
        vb[k] <= 1'b0;
      end
    end else if (en) begin
      vb[0] <= in_valid;
      for (int k = 1; k < 6; k++) begin
        vb[k] <= vb[k-1];
      end
    end
  end

  always_comb begin
    vmax_w = vsq[0];
    for (int i = 1; i < 6; i++) begin
      if (vsq[i] > vmax_w) begin
        vmax_w = vsq[i];
      end
    end
    emin_w = esq[0];
    for (int i = 1; i < 6; i++) begin
      if (esq[i] < emin_w) begin
        emin_w = esq[i];
      end
    end
    for (int i = 0; i < 6; i++) begin
      t_w[i]  = -(TW'(dot[i]) * TW'(3));
      tt_w[i] = t_w[i] + (TW'(1) <<< (F - 1));
      if (t_w[i] < 0) begin
        pick_w[i] = PICK_START;
      end else if (t_w[i] > (TW'(1) <<< (2 * F))) begin
        pick_w[i] = PICK_END;
      end else begin
        pick_w[i] = PICK_PROJ;
      end
      ox_w[i]   = (OW'(tf[i]) * OW'(labs(edx(i))) + (OW'(1) << (F - 1))) >> F;
      oy_w[i]   = (OW'(tf[i]) * OW'(labs(edy(i))) + (OW'(1) << (F - 1))) >> F;
      offx_w[i] = (edx(i) < 0) ? -CW'(ox_w[i]) : CW'(ox_w[i]);
      offy_w[i] = (edy(i) < 0) ? -CW'(oy_w[i]) : CW'(oy_w[i]);
      case (pick[i])
        PICK_START: begin
          ptx_w[i] = p3x[i];
          pty_w[i] = p3y[i];
        end
        PICK_END: begin
          ptx_w[i] = p3x[nxt(i)];
          pty_w[i] = p3y[nxt(i)];
        end
        default: begin
          ptx_w[i] = p3x[i] + offx_w[i];
          pty_w[i] = p3y[i] + offy_w[i];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= {sat_c(cx), sat_c(cy), ring};
      for (int k = 1; k < 6; k++) begin
        sd[k] <= sd[k-1];
      end
      for (int i = 0; i < 6; i++) begin
        p1x[i]  <= cx + CW'(off_x(i));
        p1y[i]  <= cy + CW'(off_y(i));
        dot[i]  <= DW'(p1x[i]) * DW'(edx(i)) + DW'(p1y[i]) * DW'(edy(i));
        vsq[i]  <= SW'(sq_c(p1x[i])) + SW'(sq_c(p1y[i]));
        p2x[i]  <= p1x[i];
        p2y[i]  <= p1y[i];
        p3x[i]  <= p2x[i];
        p3y[i]  <= p2y[i];
        pick[i] <= pick_w[i];
        tf[i]   <= tt_w[i][2*F:F];
        ptx[i]  <= ptx_w[i];
        pty[i]  <= pty_w[i];
        esq[i]  <= SW'(sq_c(ptx[i])) + SW'(sq_c(pty[i]));
      end
      qdx  <= QW'(qx) - QW'(cx);
      qdy  <= QW'(qy) - QW'(cy);
      q2   <= QSW'(sq_q(qdx)) + QSW'(sq_q(qdy));
      q3   <= q2;
      q4   <= q3;
      q5   <= q4;
      q6   <= q5;
      vm3  <= vmax_w;
      vm4  <= vm3;
      vm5  <= vm4;
      vm6  <= vm5;
      emin <= emin_w;
    end
  end

  assign sq_din[0] = NE'(emin);
  assign sq_din[1] = NE'(vm6);
  assign sq_din[2] = NE'(q6);

  hcg_isqrt #(
    .NE    (NE),
    .LANES (3),
    .TW    (SIDE_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vb[5]),
    .din       (sq_din),
    .tag_in    (sd[5]),
    .out_valid (sq_valid),
    .root      (sq_root),
    .tag_out   (sq_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      m_valid   <= sq_valid;
      out_valid <= m_valid;
    end
  end

  assign qsum = (PW+1)'(m_prod) + ((PW+1)'(1) << (F - 1));
  assign qs   = qsum[PW:F];

  always_ff @(posedge clk) begin
    if (en) begin
      m_side  <= sq_tag;
      m_inner <= (sq_root[0] > RW'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : sq_root[0][DIST_W-1:0];
      m_outer <= (sq_root[1] > RW'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : sq_root[1][DIST_W-1:0];
      m_prod  <= PW'(sq_root[2]) * PW'(scale);
      {center_x, center_y, ring_number} <= m_side;
      inner_distance <= m_inner;
      outer_distance <= m_outer;
      query_distance <= (|qs[PW-F:QDIST_W]) ? {QDIST_W{1'b1}} : qs[QDIST_W-1:0];
    end
  end
endmodule

### design/hex_cell_geometry.sv
// Hex cell geometry top level: config register, front end, queue, back end.
// Throughput: one item per cycle while the output is not stalled; the root pipeline advances one bit per stage.
// Output stalls hold the back end; the two-entry queue lets the front end keep accepting until it fills.
// Reset (rst, synchronous): pipelines and queue empty, scale_factor back to 1.0.
module hex_cell_geometry import hcg_pkg::*; #(
  parameter int INDEX_LIMIT   = 63,
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [SCALE_W-1:0]          cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [AXIAL_W-1:0]   axial_u,
  input  logic signed [AXIAL_W-1:0]   axial_v,
  input  logic signed [QUERY_W-1:0]   query_x,
  input  logic signed [QUERY_W-1:0]   query_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [CENTER_W-1:0]  center_x,
  output logic signed [CENTER_W-1:0]  center_y,
  output logic [RING_W-1:0]           ring_number,
  output logic [DIST_W-1:0]           inner_distance,
  output logic [DIST_W-1:0]           outer_distance,
  output logic [QDIST_W-1:0]          query_distance
);
  localparam int CW = FRACTION_BITS + 10;
  localparam int QW = ((CW > QUERY_W) ? CW : QUERY_W) + 1;
  localparam int PW = 2 * CW + RING_W + 2 * QUERY_W;

  logic [SCALE_W-1:0]        scale_factor;
  logic                      f_valid, f_ready, b_valid, b_ready;
  logic signed [CW-1:0]      f_cx, f_cy, b_cx, b_cy;
  logic [RING_W-1:0]         f_ring, b_ring;
  logic signed [QUERY_W-1:0] f_qx, f_qy, b_qx, b_qy;
  logic [PW-1:0]             f_pay, b_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= SCALE_RESET;
    end else if (cfg_we) begin
      scale_factor <= cfg_wdata;
    end
  end

  hcg_front #(
    .INDEX_LIMIT   (INDEX_LIMIT),
    .FRACTION_BITS (FRACTION_BITS),
    .CW            (CW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .axial_u  (axial_u),
    .axial_v  (axial_v),
    .query_x  (query_x),
    .query_y  (query_y),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .cx       (f_cx),
    .cy       (f_cy),
    .ring     (f_ring),
    .qx       (f_qx),
    .qy       (f_qy)
  );

  assign f_pay = {f_cx, f_cy, f_ring, f_qx, f_qy};

  hcg_queue #(
    .W (PW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .din_valid  (f_valid),
    .din_ready  (f_ready),
    .din        (f_pay),
    .dout_valid (b_valid),
    .dout_ready (b_ready),
    .dout       (b_pay)
  );

  assign {b_cx, b_cy, b_ring, b_qx, b_qy} = b_pay;

  hcg_back #(
    .FRACTION_BITS (FRACTION_BITS),
    .CW            (CW),
    .QW            (QW)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (b_valid),
    .in_ready       (b_ready),
    .cx             (b_cx),
    .cy             (b_cy),
    .ring           (b_ring),
    .qx             (b_qx),
    .qy             (b_qy),
    .scale          (scale_factor),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .center_x       (center_x),
    .center_y       (center_y),
    .ring_number    (ring_number),
    .inner_distance (inner_distance),
    .outer_distance (outer_distance),
    .query_distance (query_distance)
  );
endmodule

### design/hcg_checker.sv
// Port-level checker for the hex cell geometry block, with its bind.
`include "hex_cell_geometry_defines.svh"
module hcg_checker import hcg_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [CENTER_W-1:0] center_x,
  input logic signed [CENTER_W-1:0] center_y,
  input logic [RING_W-1:0]          ring_number,
  input logic [QDIST_W-1:0]         query_distance
);
  `HCG_ASSERT_AFTER_RST(a_rst_idle, !out_valid)
  `HCG_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(center_x) && $stable(query_distance))
  `HCG_ASSERT_IMP(a_origin_cell, out_valid && ring_number == '0, center_x == '0 && center_y == '0)
endmodule

bind hex_cell_geometry hcg_checker u_hcg_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .center_x       (center_x),
  .center_y       (center_y),
  .ring_number    (ring_number),
  .query_distance (query_distance)
);

### dv/tb_top.sv
// Self-checking testbench for the hex cell geometry block.
`timescale 1ns / 100ps
module tb_top;
  import hcg_pkg::*;

  typedef struct packed {
    logic signed [AXIAL_W-1:0] u;
    logic signed [AXIAL_W-1:0] v;
    logic signed [QUERY_W-1:0] qx;
    logic signed [QUERY_W-1:0] qy;
  } cell_req_t;

  typedef struct packed {
    logic signed [CENTER_W-1:0] cx;
    logic signed [CENTER_W-1:0] cy;
    logic [RING_W-1:0]          ring;
    logic [DIST_W-1:0]          inner;
    logic [DIST_W-1:0]          outer;
    logic [QDIST_W-1:0]         qdist;
  } cell_geom_t;

  typedef struct {
    cell_req_t  req;
    bit         known;
    cell_geom_t geom;
  } stim_row_t;

  localparam int FB = 16;
  localparam int LIMIT = 63;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [SCALE_W-1:0] cfg_wdata = '0;
  logic in_valid = 0, in_ready;
  logic signed [AXIAL_W-1:0] axial_u = '0, axial_v = '0;
  logic signed [QUERY_W-1:0] query_x = '0, query_y = '0;
  logic out_valid, out_ready = 0;
  logic signed [CENTER_W-1:0] center_x, center_y;
  logic [RING_W-1:0] ring_number;
  logic [DIST_W-1:0] inner_distance, outer_distance;
  logic [QDIST_W-1:0] query_distance;

  hex_cell_geometry dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  cell_geom_t pending_geom[$];
  logic [SCALE_W-1:0] scale_reg = SCALE_RESET;
  int errors = 0;
  bit sink_idle_en = 1;

  function automatic longint round_shift(longint x, int s);
    longint h;
    h = longint'(1) << (s - 1);
    if (x >= 0) return (x + h) >>> s;
    return -((-x + h) >>> s);
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint radius(longint x, longint y);
    longint unsigned ax, ay;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    return int_sqrt(ax * ax + ay * ay);
  endfunction

  function automatic longint side_gap(longint ax, longint ay, longint bx, longint by);
    longint dx, dy, t, tf;
    dx = bx - ax;
    dy = by - ay;
    t = -3 * (dx * ax + dy * ay);
    if (t < 0) return radius(ax, ay);
    if (t > (longint'(1) << (2 * FB))) return radius(bx, by);
    tf = round_shift(t, FB);
    return radius(ax + round_shift(tf * dx, FB), ay + round_shift(tf * dy, FB));
  endfunction

  function automatic cell_geom_t cell_geometry(cell_req_t r, logic [SCALE_W-1:0] sc);
    cell_geom_t g;
    longint u, v, qx, qy, so, lo, hf, cx, cy, au, av, rg, d;
    longint px[6], py[6];
    longint unsigned inner, outer, qd;
    u = r.u; v = r.v; qx = r.qx; qy = r.qy;
    u = u < -LIMIT ? -LIMIT : (u > LIMIT ? LIMIT : u);
    v = v < -LIMIT ? -LIMIT : (v > LIMIT ? LIMIT : v);
    so = round_shift(longint'(SHORT_OFF_Q32), 32 - FB);
    lo = round_shift(longint'(LONG_OFF_Q32), 32 - FB);
    hf = longint'(1) << (FB - 1);
    cx = round_shift((u + v) * longint'(HALF_SQRT3_Q32), 32 - FB);
    cy = (u - v) * hf;
    px[0] = cx - so; py[0] = cy - hf;
    px[1] = cx + so; py[1] = cy - hf;
    px[2] = cx + lo; py[2] = cy;
    px[3] = cx + so; py[3] = cy + hf;
    px[4] = cx - so; py[4] = cy + hf;
    px[5] = cx - lo; py[5] = cy;
    inner = '1;
    outer = 0;
    for (int i = 0; i < 6; i++) begin
      d = side_gap(px[i], py[i], px[(i + 1) % 6], py[(i + 1) % 6]);
      if (d < inner) inner = d;
      d = radius(px[i], py[i]);
      if (d > outer) outer = d;
    end
    au = u < 0 ? -u : u;
    av = v < 0 ? -v : v;
    if (u * v > 0) rg = (u + v) < 0 ? -(u + v) : (u + v);
    else rg = au > av ? au : av;
    if (rg > 127) rg = 127;
    qd = radius(qx - cx, qy - cy) * longint'(sc);
    qd = (qd + (longint'(1) << (FB - 1))) >> FB;
    if (qd > 64'hFFFF_FFFF) qd = 64'hFFFF_FFFF;
    g.cx = CENTER_W'(cx < CENTER_MIN ? CENTER_MIN : (cx > CENTER_MAX ? CENTER_MAX : cx));
    g.cy = CENTER_W'(cy < CENTER_MIN ? CENTER_MIN : (cy > CENTER_MAX ? CENTER_MAX : cy));
    g.ring = RING_W'(rg);
    g.inner = inner > 64'h7F_FFFF ? 23'h7F_FFFF : DIST_W'(inner);
    g.outer = outer > 64'h7F_FFFF ? 23'h7F_FFFF : DIST_W'(outer);
    g.qdist = QDIST_W'(qd);
    return g;
  endfunction

  task automatic send_cell(cell_req_t r, bit known, cell_geom_t g, bit idle_en);
    cell_geom_t pg;
    while (idle_en && $urandom_range(99) < 35) begin
      in_valid <= 0;
      @(negedge clk);
    end
    pg = cell_geometry(r, scale_reg);
    if (known && pg !== g)
      $display("%0t note: table row disagrees with predictor, exp %h got %h", $time, g, pg);
    in_valid <= 1;
    axial_u <= r.u; axial_v <= r.v; query_x <= r.qx; query_y <= r.qy;
    do @(posedge clk); while (!in_ready);
    pending_geom.push_back(known ? g : pg);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 0;
    while (pending_geom.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] val);
    drain_results();
    cfg_we <= 1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    scale_reg = val;
  endtask

  function automatic cell_req_t rand_cell();
    cell_req_t r;
    r.u = AXIAL_W'($urandom);
    r.v = AXIAL_W'($urandom);
    case ($urandom_range(3))
      0: begin r.qx = QUERY_W'($urandom); r.qy = QUERY_W'($urandom); end
      1: begin
        r.qx = QUERY_W'($urandom_range(1023) - 512);
        r.qy = QUERY_W'($urandom_range(1023) - 512);
      end
      default: begin
        r.qx = QUERY_W'(($urandom_range(8191) - 4096) * 64);
        r.qy = QUERY_W'(($urandom_range(8191) - 4096) * 64);
      end
    endcase
    if ($urandom_range(3) == 0) begin
      r.u = AXIAL_W'($urandom_range(6) - 3);
      r.v = AXIAL_W'($urandom_range(6) - 3);
    end
    return r;
  endfunction

  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= !(sink_idle_en && $urandom_range(99) < 35);
  end

  always @(posedge clk) begin
    cell_geom_t got, exp_g;
    if (!rst && out_valid && out_ready) begin
      got = '{center_x, center_y, ring_number, inner_distance, outer_distance,
              query_distance};
      if (pending_geom.size() == 0) begin
        $display("%0t unexpected transaction %h", $time, got);
        errors++;
      end else begin
        exp_g = pending_geom.pop_front();
        if (got.cx !== exp_g.cx) begin
          $display("%0t center_x exp %0d got %0d", $time, exp_g.cx, got.cx); errors++;
        end
        if (got.cy !== exp_g.cy) begin
          $display("%0t center_y exp %0d got %0d", $time, exp_g.cy, got.cy); errors++;
        end
        if (got.ring !== exp_g.ring) begin
          $display("%0t ring_number exp %0d got %0d", $time, exp_g.ring, got.ring); errors++;
        end
        if (got.inner !== exp_g.inner) begin
          $display("%0t inner_distance exp %0d got %0d", $time, exp_g.inner, got.inner);
          errors++;
        end
        if (got.outer !== exp_g.outer) begin
          $display("%0t outer_distance exp %0d got %0d", $time, exp_g.outer, got.outer);
          errors++;
        end
        if (got.qdist !== exp_g.qdist) begin
          $display("%0t query_distance exp %0d got %0d", $time, exp_g.qdist, got.qdist);
          errors++;
        end
      end
    end
  end

  stim_row_t dir_rows[$];

  initial begin
    cell_req_t r;
    stim_row_t row;
    dir_rows.push_back('{'{7'sd0, 7'sd0, 24'sd0, 24'sd0}, 1,
                         '{24'sd0, 24'sd0, 7'd0, 23'd32768, 23'd37837, 32'd0}});
    dir_rows.push_back('{'{7'sd0, 7'sd0, 24'sd65536, 24'sd0}, 1,
                         '{24'sd0, 24'sd0, 7'd0, 23'd32768, 23'd37837, 32'd65536}});
    dir_rows.push_back('{'{7'sd1, 7'sd1, 0, 0}, 0, '0});
    dir_rows.push_back('{'{-7'sd1, -7'sd1, 0, 0}, 0, '0});
    dir_rows.push_back('{'{7'sd1, -7'sd1, 0, 0}, 0, '0});
    dir_rows.push_back('{'{7'sd63, 7'sd63, 24'h7FFFFF, 24'h7FFFFF}, 0, '0});
    dir_rows.push_back('{'{-7'sd63, -7'sd63, 24'h800000, 24'h800000}, 0, '0});
    dir_rows.push_back('{'{-7'sd64, -7'sd64, 24'h7FFFFF, 24'h800000}, 0, '0});
    dir_rows.push_back('{'{-7'sd64, 7'sd63, 24'h800000, 24'h7FFFFF}, 0, '0});
    dir_rows.push_back('{'{7'sd63, -7'sd64, 0, 0}, 0, '0});
    dir_rows.push_back('{'{7'sd3, -7'sd5, 24'sd1000, -24'sd1000}, 0, '0});
    dir_rows.push_back('{'{7'sd0, 7'sd5, 24'h7FFFFF, 0}, 0, '0});
    dir_rows.push_back('{'{7'sd2, 7'sd0, 24'h555555, 24'h2AAAAA}, 0, '0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    foreach (dir_rows[i]) send_cell(dir_rows[i].req, dir_rows[i].known, dir_rows[i].geom, 1);

    write_scale(24'hFFFFFF);
    send_cell('{-7'sd64, -7'sd64, 24'h7FFFFF, 24'h7FFFFF}, 0, '0, 1);
    send_cell('{7'sd1, 7'sd2, 24'h800000, 24'h800000}, 0, '0, 1);
    write_scale(24'd0);
    send_cell('{7'sd5, 7'sd5, 24'h7FFFFF, 24'h7FFFFF}, 0, '0, 1);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: write_scale(24'd65536);
        1: write_scale($urandom);
        2: write_scale(24'hFFFFFF);
        3: write_scale(24'd1);
        default: write_scale($urandom_range(200000));
      endcase
      sink_idle_en = (p != 2);
      for (int k = 0; k < 100; k++) begin
        r = rand_cell();
        send_cell(r, 0, '0, p != 2);
      end
    end
    sink_idle_en = 1;

    drain_results();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
